@@ rtl/core/ctab_pkg.sv @@
`timescale 1ns / 1ps

package ctab_pkg;

  // Fixed field widths
  localparam int ID_W  = 32;
  localparam int TS_W  = 32;
  localparam int THR_W = 16;
  localparam int OCC_W = 7;
  localparam int EV_W  = 3;

  localparam logic [THR_W-1:0] THR_RESET = 16'd5;

  // Result event codes
  typedef enum logic [EV_W-1:0] {
    EV_IGNORED    = 3'd0,
    EV_REFRESHED  = 3'd1,
    EV_NEW        = 3'd2,
    EV_FULL       = 3'd3,
    EV_LEFT       = 3'd4,
    EV_SWEEP_NONE = 3'd5
  } ev_t;

  // Memory read address source
  typedef enum logic {
    RA_IDX,
    RA_CNT
  } rd_sel_t;

  // Memory write address source
  typedef enum logic {
    WA_IDX,
    WA_CNT
  } wa_sel_t;

  // Memory write data source
  typedef enum logic {
    WD_ITEM,
    WD_MOVED
  } wd_sel_t;

  // What the output register takes this cycle
  typedef enum logic [1:0] {
    EM_OFF,
    EM_ITEM,
    EM_PEND,
    EM_EMPTY
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    pend_set;
    logic    pend_clr;
    emit_t   emit;
    ev_t     ev;
    logic    last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic kind;
    logic in_range;
    logic idx_lt_cnt;
    logic idx_is_tail;
    logic full;
    logic id_match;
    logic expired;
    logic pend_valid;
  } sts_t;

endpackage

@@ rtl/core/ctab_ctrl.sv @@
`timescale 1ns / 1ps

module ctab_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ctab_pkg::sts_t sts,
  output ctab_pkg::cmd_t cmd
);
  import ctab_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_ENC_RD,
    S_ENC_CHK,
    S_SW_RD,
    S_SW_CHK,
    S_SW_TRD,
    S_SW_MOV
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RA_IDX;
    cmd.wa_sel = WA_IDX;
    cmd.wd_sel = WD_ITEM;
    cmd.emit   = EM_OFF;
    cmd.ev     = EV_IGNORED;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.kind) begin
          cmd.pend_clr = 1'b1;
          state_nxt    = S_SW_RD;
        end else if (!sts.in_range) begin
          cmd.emit  = EM_ITEM;
          cmd.ev    = EV_IGNORED;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ENC_RD;
        end
      end
      // encounter: look up the id one entry at a time
      S_ENC_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_ENC_CHK;
        end else if (sts.full) begin
          cmd.emit  = EM_ITEM;
          cmd.ev    = EV_FULL;
          state_nxt = S_IDLE;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = WA_CNT;
          cmd.cnt_inc = 1'b1;
          cmd.emit    = EM_ITEM;
          cmd.ev      = EV_NEW;
          state_nxt   = S_IDLE;
        end
      end
      S_ENC_CHK: begin
        if (sts.id_match) begin
          cmd.wr_en = 1'b1;
          cmd.emit  = EM_ITEM;
          cmd.ev    = EV_REFRESHED;
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_ENC_RD;
        end
      end
      // sweep: one removal is held back so the final one can carry last
      S_SW_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SW_CHK;
        end else if (sts.pend_valid) begin
          cmd.emit     = EM_PEND;
          cmd.last     = 1'b1;
          cmd.pend_clr = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.emit  = EM_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      S_SW_CHK: begin
        if (!sts.expired) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SW_RD;
        end else begin
          cmd.pend_set = 1'b1;
          cmd.cnt_dec  = 1'b1;
          if (sts.pend_valid) begin
            cmd.emit = EM_PEND;
          end
          state_nxt = sts.idx_is_tail ? S_SW_RD : S_SW_TRD;
        end
      end
      // fetch the tail entry (count already decremented)
      S_SW_TRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_CNT;
        state_nxt  = S_SW_MOV;
      end
      S_SW_MOV: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = WD_MOVED;
        state_nxt  = S_SW_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

@@ rtl/core/ctab_datapath.sv @@
`timescale 1ns / 1ps

module ctab_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctab_pkg::cmd_t              cmd,
  output ctab_pkg::sts_t              sts,
  input  logic                        in_kind,
  input  logic [ctab_pkg::ID_W-1:0]   in_neighbor_id,
  input  logic [ctab_pkg::TS_W-1:0]   in_now_seconds,
  input  logic                        in_in_range,
  input  logic                        cfg_valid,
  input  logic [ctab_pkg::THR_W-1:0]  cfg_age_threshold,
  output logic                        out_valid,
  output logic [ctab_pkg::EV_W-1:0]   out_event_res,
  output logic [ctab_pkg::ID_W-1:0]   out_event_id,
  output logic [ctab_pkg::OCC_W-1:0]  out_occupancy,
  output logic                        out_last
);
  import ctab_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int WORD_W = ID_W + TS_W;

  // Table memory: {id, last_heard}
  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;

  // Item and control registers
  logic              kind_r, inr_r;
  logic [ID_W-1:0]   id_r;
  logic [TS_W-1:0]   now_r;
  logic [THR_W-1:0]  thr_r;
  logic [CNT_W-1:0]  idx_r, cnt_r, cnt_nxt;
  logic              pend_valid_r;
  logic [ID_W-1:0]   pend_id_r;
  logic [CNT_W-1:0]  pend_occ_r;

  logic              out_valid_r, out_last_r;
  logic [EV_W-1:0]   out_ev_r;
  logic [ID_W-1:0]   out_id_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic [ID_W-1:0]   rd_id;
  logic [TS_W-1:0]   rd_lh;
  logic [TS_W:0]     expiry;

  assign rd_id = rd_data_r[WORD_W-1:TS_W];
  assign rd_lh = rd_data_r[TS_W-1:0];

  // Address and data selection
  assign rd_addr = (cmd.rd_sel == RA_CNT) ? cnt_r[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign wr_addr = (cmd.wa_sel == WA_CNT) ? cnt_r[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign wr_data = (cmd.wd_sel == WD_MOVED) ? rd_data_r : {id_r, now_r};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      id_r   <= in_neighbor_id;
      now_r  <= in_now_seconds;
      inr_r  <= in_in_range;
    end
  end

  // Entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Count, index, threshold, held-back removal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      thr_r        <= THR_RESET;
      pend_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid) begin
        thr_r <= cfg_age_threshold;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.pend_set) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.pend_clr) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_id_r  <= rd_id;
      pend_occ_r <= cnt_nxt;
    end
  end

  // 33-bit age compare, never wraps
  assign expiry = {1'b0, rd_lh} + (TS_W + 1)'(thr_r);

  assign sts.kind        = kind_r;
  assign sts.in_range    = inr_r;
  assign sts.idx_lt_cnt  = (idx_r < cnt_r);
  assign sts.idx_is_tail = ((idx_r + CNT_W'(1)) == cnt_r);
  assign sts.full        = (cnt_r == CNT_W'(CAPACITY));
  assign sts.id_match    = (rd_id == id_r);
  assign sts.expired     = (expiry <= {1'b0, now_r});
  assign sts.pend_valid  = pend_valid_r;

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != EM_OFF);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EM_ITEM: begin
        out_ev_r   <= cmd.ev;
        out_id_r   <= id_r;
        out_occ_r  <= OCC_W'(cnt_nxt);
        out_last_r <= 1'b1;
      end
      EM_PEND: begin
        out_ev_r   <= EV_LEFT;
        out_id_r   <= pend_id_r;
        out_occ_r  <= OCC_W'(pend_occ_r);
        out_last_r <= cmd.last;
      end
      EM_EMPTY: begin
        out_ev_r   <= EV_SWEEP_NONE;
        out_id_r   <= '0;
        out_occ_r  <= OCC_W'(cnt_r);
        out_last_r <= 1'b1;
      end
      EM_OFF: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_ev_r;
  assign out_event_id  = out_id_r;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_inc_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (cnt_r < CNT_W'(CAPACITY)))
    else $error("append into full table");

  a_no_dec_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (cnt_r != '0))
    else $error("removal from empty table");

  a_last_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit == EM_PEND && cmd.last) |=> !pend_valid_r)
    else $error("held removal survives final result");
`endif

endmodule

@@ rtl/core/contact_table_with_aging_unit.sv @@
`timescale 1ns / 1ps

// Contact table with aging.
// Request channel: present in_kind, in_neighbor_id, in_now_seconds, in_in_range
// and raise start; the request is taken at an edge where start is high and busy
// is low. busy stays high until the last result of the request has been issued.
// Results come out on out_* for exactly one cycle each, marked by out_valid;
// out_last flags the final result of a request. The receiver cannot stall.
// Encounter out of range: answered from the dispatch state. Refresh: entries are
// scanned up to the match (one memory read and one compare per entry). New or
// dropped entry: every table entry is scanned first. One result.
// Sweep: one read and one compare per entry; a removed entry that is not the
// tail is replaced by a tail move (a read and a write on the single table
// memory); one LEAVE result per removal, or one "none removed" result.
// A new request can be taken at the edge that ends the final result.
// cfg_age_threshold is written when cfg_valid is high (cfg_ready is always
// high); write it only while the unit is idle.
// Reset (rst_n low, synchronous) empties the table and sets the threshold to
// 5; there is no clearing pass, the unit takes requests right after reset.

module contact_table_with_aging_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [ctab_pkg::ID_W-1:0]   in_neighbor_id,
  input  logic [ctab_pkg::TS_W-1:0]   in_now_seconds,
  input  logic                        in_in_range,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ctab_pkg::THR_W-1:0]  cfg_age_threshold,
  output logic                        out_valid,
  output logic [ctab_pkg::EV_W-1:0]   out_event_res,
  output logic [ctab_pkg::ID_W-1:0]   out_event_id,
  output logic [ctab_pkg::OCC_W-1:0]  out_occupancy,
  output logic                        out_last
);
  import ctab_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ctab_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ctab_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_neighbor_id    (in_neighbor_id),
    .in_now_seconds    (in_now_seconds),
    .in_in_range       (in_in_range),
    .cfg_valid         (cfg_valid),
    .cfg_age_threshold (cfg_age_threshold),
    .out_valid         (out_valid),
    .out_event_res     (out_event_res),
    .out_event_id      (out_event_id),
    .out_occupancy     (out_occupancy),
    .out_last          (out_last)
  );

endmodule
